@@ design/uida_pkg.sv @@
// Shared types and codes for the unique ID allocator.
package uida_pkg;

   // Width of an ID as carried on the ports and stored on the free list
   localparam int unsigned IdW = 8;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_DOUBLE    = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   // Request modes
   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   // Request transaction payload
   typedef struct packed {
      mode_type         mode;
      logic [IdW-1:0]   free_id;
   } req_payload_type;

   // Response transaction payload
   typedef struct packed {
      logic [IdW-1:0]   alloc_id;
      status_type       status;
   } rsp_payload_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_SCAN,
      S_SHIFT,
      S_INSERT,
      S_DONE
   } state_type;

endpackage

@@ design/unique_id_allocator.sv @@
// Top level of the unique ID allocator: controller, counters and free-list memory.
//
//  Port group | Direction | Handshake            | Payload
//  req_*      | in        | req_valid/req_ready  | req_data  (mode, free_id)
//  rsp_*      | out       | rsp_valid/rsp_ready  | rsp_data  (alloc_id, status)
//
// An allocate fetches the top of the list, then pops it or issues a fresh ID. A free
// first runs a read-only scan down the sorted list, then shifts the listed entries
// above the ID up one place, then inserts it; the shift is skipped when the ID sorts
// above every entry. Out of range is answered at the first scan step, a double free
// where the scan meets the ID. Both walks go by the single read port of the memory.
// Reset clears the counters and the response valid flag and holds req_ready low;
// the list memory is not cleared, only entries below the fill count are used.
// One transaction is in work at a time; a pending response stalls only the
// final load, and the next request is taken the cycle after that load.
module unique_id_allocator #(
   parameter int unsigned MAX_IDS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  uida_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output uida_pkg::rsp_payload_type rsp_data
);

   localparam int unsigned AW   = (MAX_IDS > 2) ? $clog2(MAX_IDS) : 1;
   localparam int unsigned CW   = $clog2(MAX_IDS + 1);
   localparam int unsigned CMPW = (CW > uida_pkg::IdW) ? CW : uida_pkg::IdW;
   localparam int unsigned IDW  = uida_pkg::IdW;

   // Control and counter registers
   uida_pkg::state_type       state_ff, state_in;
   logic [CW-1:0]             next_fresh_ff, next_fresh_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Payload registers
   uida_pkg::req_payload_type req_ff, req_in;
   uida_pkg::rsp_payload_type res_ff, res_in;
   uida_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic [CW-1:0]             pos_ff, pos_in;

   // Memory port
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [IDW-1:0]            wr_data;
   logic [AW-1:0]             rd_addr;
   logic [IDW-1:0]            rd_data;

   // Decision terms
   logic [CW-1:0]             count_m1;
   logic [AW-1:0]             top_ptr;
   logic [CW-1:0]             scan_pos;
   logic                      out_of_range;
   logic                      list_empty;
   logic                      hit;
   logic                      below;
   logic                      at_bottom;
   logic                      shift_end;
   logic                      fresh_left;
   logic                      rsp_free;

   uida_list_ram #(
      .Depth (MAX_IDS),
      .AddrW (AW),
      .DataW (IDW)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Compare the entry under the scan pointer and the counters
   always_comb begin
      count_m1     = count_ff - CW'(1);
      top_ptr      = count_m1[AW-1:0];
      scan_pos     = CW'(ptr_ff) + CW'(1);
      out_of_range = CMPW'(req_ff.free_id) >= CMPW'(next_fresh_ff);
      list_empty   = (count_ff == '0);
      hit          = (rd_data == req_ff.free_id);
      below        = (rd_data < req_ff.free_id);
      at_bottom    = (ptr_ff == '0);
      shift_end    = (ptr_ff == pos_ff[AW-1:0]);
      fresh_left   = (next_fresh_ff != CW'(MAX_IDS));
      rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uida_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.mode == uida_pkg::MODE_FREE) ? uida_pkg::S_SCAN
                                                                : uida_pkg::S_ALLOC;
            end
         end
         uida_pkg::S_ALLOC: begin
            state_in = uida_pkg::S_DONE;
         end
         uida_pkg::S_SCAN: begin
            if (out_of_range) begin
               state_in = uida_pkg::S_DONE;
            end else if (list_empty) begin
               state_in = uida_pkg::S_INSERT;
            end else if (hit) begin
               state_in = uida_pkg::S_DONE;
            end else if (below) begin
               state_in = (scan_pos == count_ff) ? uida_pkg::S_INSERT : uida_pkg::S_SHIFT;
            end else if (at_bottom) begin
               state_in = uida_pkg::S_SHIFT;
            end
         end
         uida_pkg::S_SHIFT: begin
            if (shift_end) begin
               state_in = uida_pkg::S_INSERT;
            end
         end
         uida_pkg::S_INSERT: begin
            state_in = uida_pkg::S_DONE;
         end
         uida_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = uida_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = uida_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath, memory port and handshake outputs
   always_comb begin
      req_in        = req_ff;
      res_in        = res_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      next_fresh_in = next_fresh_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      rd_addr       = top_ptr;
      wr_en         = 1'b0;
      wr_addr       = pos_ff[AW-1:0];
      wr_data       = req_ff.free_id;

      case (state_ff)
         uida_pkg::S_IDLE: begin
            // Take a transaction and fetch the top of the list; hold off in reset
            req_ready = !reset;
            if (req_valid) begin
               req_in = req_data;
               ptr_in = top_ptr;
            end
         end
         uida_pkg::S_ALLOC: begin
            // Pop the largest free ID, else issue a fresh one, else report exhaustion
            if (!list_empty) begin
               res_in.alloc_id = rd_data;
               res_in.status   = uida_pkg::ST_OK;
               count_in        = count_m1;
            end else if (fresh_left) begin
               res_in.alloc_id = IDW'(CMPW'(next_fresh_ff));
               res_in.status   = uida_pkg::ST_OK;
               next_fresh_in   = next_fresh_ff + CW'(1);
            end else begin
               res_in.alloc_id = '0;
               res_in.status   = uida_pkg::ST_EXHAUSTED;
            end
         end
         uida_pkg::S_SCAN: begin
            // Check the range, then walk down the list until an entry at or below the ID
            res_in.alloc_id = '0;
            if (out_of_range) begin
               res_in.status = uida_pkg::ST_RANGE;
            end else if (list_empty) begin
               pos_in = '0;
            end else if (hit) begin
               res_in.status = uida_pkg::ST_DOUBLE;
            end else if (below) begin
               pos_in = scan_pos;
               ptr_in = top_ptr;
            end else if (at_bottom) begin
               pos_in = '0;
               ptr_in = top_ptr;
            end else begin
               ptr_in  = ptr_ff - AW'(1);
               rd_addr = ptr_ff - AW'(1);
            end
         end
         uida_pkg::S_SHIFT: begin
            // Move each larger entry up one place, top first
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
            wr_data = rd_data;
            if (!shift_end) begin
               ptr_in  = ptr_ff - AW'(1);
               rd_addr = ptr_ff - AW'(1);
            end
         end
         uida_pkg::S_INSERT: begin
            // Drop the ID into its sorted slot
            wr_en           = 1'b1;
            count_in        = count_ff + CW'(1);
            res_in.alloc_id = '0;
            res_in.status   = uida_pkg::ST_OK;
         end
         uida_pkg::S_DONE: begin
            // Load the response register once it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= uida_pkg::S_IDLE;
         next_fresh_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_fresh_ff <= next_fresh_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      ptr_ff      <= ptr_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/uida_list_ram.sv @@
// Free-list storage: one write port, one read port, registered read data.
module uida_list_ram #(
   parameter int unsigned Depth = 256,
   parameter int unsigned AddrW = 8,
   parameter int unsigned DataW = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [DataW-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [DataW-1:0] rd_data
);

   logic [DataW-1:0] mem_ff [Depth];
   logic [DataW-1:0] rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read every cycle, data registered and valid in the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
